>>> rtl/core/greedy_facility_location_round_macros.svh
// assertion macros for the greedy facility location round block
// expects clk_i and rst_ni in the scope of use
`ifndef GREEDY_FACILITY_LOCATION_ROUND_MACROS_SVH
`define GREEDY_FACILITY_LOCATION_ROUND_MACROS_SVH

// same-cycle implication
`define GFLR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GFLR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/gflr_pkg.sv
// shared codes and port widths of the greedy facility location round block
// no dependencies
`default_nettype none

package gflr_pkg;

  localparam int unsigned REQ_W   = 2;
  localparam int unsigned FAC_W   = 3;
  localparam int unsigned CLI_W   = 4;
  localparam int unsigned COSTI_W = 16;
  localparam int unsigned NUM_W   = 22;
  localparam int unsigned DEN_W   = 5;

  typedef logic [REQ_W-1:0] req_t;

  localparam req_t REQ_CONN  = 2'd0;
  localparam req_t REQ_OPEN  = 2'd1;
  localparam req_t REQ_ROUND = 2'd2;

endpackage

`default_nettype wire

>>> rtl/core/gflr_ram.sv
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
`default_nettype none

module gflr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/greedy_facility_location_round.sv
// a load gives no result; the length of a round grows with the longest walk s
//   and with output stalls, since every walk step rescans all C clients
// throughput: one item at a time, the next is taken once the round is over
// reset: served, opened and control state cleared; cost memories undefined
`default_nettype none

`include "greedy_facility_location_round_macros.svh"

module greedy_facility_location_round #(
  parameter int unsigned FACILITIES = 8,
  parameter int unsigned CLIENTS    = 16,
  parameter int unsigned COST_WIDTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [gflr_pkg::REQ_W-1:0]    req_type_i,
  input  wire logic [gflr_pkg::FAC_W-1:0]    facility_i,
  input  wire logic [gflr_pkg::CLI_W-1:0]    client_i,
  input  wire logic [gflr_pkg::COSTI_W-1:0]  cost_value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [gflr_pkg::CLI_W-1:0]         client_out_o,
  output logic [gflr_pkg::FAC_W-1:0]         facility_out_o,
  output logic signed [gflr_pkg::NUM_W-1:0]  ratio_numerator_o,
  output logic [gflr_pkg::DEN_W-1:0]         ratio_denominator_o,
  output logic                               switched_o,
  output logic                               newly_opened_o,
  output logic                               all_served_o,
  output logic                               last_o
);

  // index and arithmetic widths
  localparam int unsigned FIW = FACILITIES > 1 ? $clog2(FACILITIES) : 1;
  localparam int unsigned CIW = CLIENTS > 1 ? $clog2(CLIENTS) : 1;
  localparam int unsigned CJW = $clog2(CLIENTS + 1);
  localparam int unsigned AW  = (FACILITIES * CLIENTS) > 1 ? $clog2(FACILITIES * CLIENTS) : 1;
  localparam int unsigned DW  = $clog2(CLIENTS + 1);
  localparam int unsigned SW  = COST_WIDTH + CJW;
  localparam int unsigned NW  = SW + 2;
  localparam int unsigned PW  = NW + DW + 1;
  localparam int unsigned OW  = NW > gflr_pkg::NUM_W ? NW : gflr_pkg::NUM_W;
  localparam int unsigned ODW = DW > gflr_pkg::DEN_W ? DW : gflr_pkg::DEN_W;
  localparam int unsigned OCW = CIW > gflr_pkg::CLI_W ? CIW : gflr_pkg::CLI_W;
  localparam int unsigned OFW = FIW > gflr_pkg::FAC_W ? FIW : gflr_pkg::FAC_W;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DONE  = 4'd1;
  localparam logic [3:0] S_PRE   = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_STEP  = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_DEC   = 4'd6;
  localparam logic [3:0] S_NEXTF = 4'd7;
  localparam logic [3:0] S_EMS   = 4'd8;
  localparam logic [3:0] S_SWE   = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  // scan purposes
  localparam logic [1:0] M_WALK = 2'd0;
  localparam logic [1:0] M_SW   = 2'd1;
  localparam logic [1:0] M_STAR = 2'd2;

  // control state
  logic [3:0]      state_q, state_d;
  logic [1:0]      mode_q, mode_d;
  logic [1:0]      ph_q, ph_d;
  logic [FIW-1:0]  i_q, i_d;
  logic [CJW-1:0]  j_q, j_d;
  logic [CIW-1:0]  jd_q, jd_d;
  logic            rdv_q, rdv_d;
  logic            first_q, first_d;
  logic [DW-1:0]   k_q, k_d;
  logic            lvalid_q, lvalid_d;
  logic            bvalid_q, bvalid_d;
  logic            prev_valid_q, prev_valid_d;
  logic            cand_valid_q, cand_valid_d;
  logic [CLIENTS-1:0]    served_q, served_d;
  logic [CLIENTS-1:0]    star_q, star_d;
  logic [CLIENTS-1:0]    sw_q, sw_d;
  logic [FACILITIES-1:0] opened_q, opened_d;
  logic            out_valid_q, out_valid_d;

  // datapath state
  logic [SW-1:0]          delta_q, delta_d;
  logic [SW-1:0]          sum_q, sum_d;
  logic signed [NW-1:0]   num_q, num_d;
  logic [DW-1:0]          den_q, den_d;
  logic signed [NW-1:0]   ln_q, ln_d;
  logic [DW-1:0]          ld_q, ld_d;
  logic signed [NW-1:0]   bnum_q, bnum_d;
  logic [DW-1:0]          bden_q, bden_d;
  logic [FIW-1:0]         bf_q, bf_d;
  logic [COST_WIDTH-1:0]  prev_cost_q, prev_cost_d;
  logic [CIW-1:0]         prev_idx_q, prev_idx_d;
  logic [COST_WIDTH-1:0]  cand_cost_q, cand_cost_d;
  logic [CIW-1:0]         cand_idx_q, cand_idx_d;
  logic signed [PW-1:0]   p1_q, p2_q, p3_q, p4_q;
  logic signed [PW-1:0]   p1_d, p2_d, p3_d, p4_d;

  // output item registers
  logic [gflr_pkg::CLI_W-1:0]        oc_q, oc_d;
  logic [gflr_pkg::FAC_W-1:0]        of_q, of_d;
  logic signed [gflr_pkg::NUM_W-1:0] on_q, on_d;
  logic [gflr_pkg::DEN_W-1:0]        od_q, od_d;
  logic osw_q, osw_d, onew_q, onew_d, odone_q, odone_d, olast_q, olast_d;

  // memory ports
  logic                  conn_we;
  logic [AW-1:0]         conn_waddr, conn_raddr;
  logic [COST_WIDTH-1:0] conn_rdata;
  logic                  open_we;
  logic [COST_WIDTH-1:0] open_rdata;
  logic                  fac_we;
  logic [CIW-1:0]        fac_waddr;
  logic [FIW-1:0]        fac_rdata;
  logic                  cur_we;
  logic [COST_WIDTH-1:0] cur_rdata;

  logic                  in_acc;
  logic                  can_emit;
  logic [CIW-1:0]        jx;
  logic [COST_WIDTH-1:0] cost_in;
  logic [COST_WIDTH-1:0] open_eff;
  logic signed [OW-1:0]  num_ext;
  logic [ODW-1:0]        den_ext;
  logic [OFW-1:0]        fac_ext;
  logic [OCW-1:0]        cli_ext;

  assign in_acc   = in_valid_i & ~in_stall_o;
  assign can_emit = ~out_valid_q | ~out_stall_i;
  assign jx       = j_q[CIW-1:0];
  assign cost_in  = COST_WIDTH'(cost_value_i);
  assign open_eff = opened_q[i_q] ? '0 : open_rdata;

  // shared output formatting of the winning ratio and facility
  assign num_ext = OW'(bnum_q);
  assign den_ext = ODW'(bden_q);
  assign fac_ext = OFW'(bf_q);

  // load writes straight from the input item
  assign conn_we    = in_acc && req_type_i == gflr_pkg::REQ_CONN
                      && 32'(facility_i) < FACILITIES && 32'(client_i) < CLIENTS;
  assign conn_waddr = AW'(facility_i) * AW'(CLIENTS) + AW'(client_i);
  assign open_we    = in_acc && req_type_i == gflr_pkg::REQ_OPEN
                      && 32'(facility_i) < FACILITIES;

  // cost memory read: served client's current facility in the prepass,
  // the facility under evaluation everywhere else
  assign conn_raddr = (state_q == S_PRE)
                      ? AW'(fac_rdata) * AW'(CLIENTS) + AW'(jx)
                      : AW'(i_q) * AW'(CLIENTS) + AW'(jx);

  // current cost of each served client is refreshed at the start of a round
  assign cur_we = (state_q == S_PRE) && (ph_q == 2'd2);

  gflr_ram #(.WIDTH(COST_WIDTH), .DEPTH(FACILITIES * CLIENTS)) u_conn (
    .clk_i   (clk_i),
    .we_i    (conn_we),
    .waddr_i (conn_waddr),
    .wdata_i (cost_in),
    .raddr_i (conn_raddr),
    .rdata_o (conn_rdata)
  );

  gflr_ram #(.WIDTH(COST_WIDTH), .DEPTH(FACILITIES)) u_open (
    .clk_i   (clk_i),
    .we_i    (open_we),
    .waddr_i (FIW'(facility_i)),
    .wdata_i (cost_in),
    .raddr_i (i_q),
    .rdata_o (open_rdata)
  );

  gflr_ram #(.WIDTH(FIW), .DEPTH(CLIENTS)) u_fac (
    .clk_i   (clk_i),
    .we_i    (fac_we),
    .waddr_i (fac_waddr),
    .wdata_i (bf_q),
    .raddr_i (jx),
    .rdata_o (fac_rdata)
  );

  gflr_ram #(.WIDTH(COST_WIDTH), .DEPTH(CLIENTS)) u_cur (
    .clk_i   (clk_i),
    .we_i    (cur_we),
    .waddr_i (jx),
    .wdata_i (conn_rdata),
    .raddr_i (jx),
    .rdata_o (cur_rdata)
  );

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    ph_d         = ph_q;
    i_d          = i_q;
    j_d          = j_q;
    jd_d         = jx;
    rdv_d        = 1'b0;
    first_d      = first_q;
    k_d          = k_q;
    lvalid_d     = lvalid_q;
    bvalid_d     = bvalid_q;
    prev_valid_d = prev_valid_q;
    cand_valid_d = cand_valid_q;
    served_d     = served_q;
    star_d       = star_q;
    sw_d         = sw_q;
    opened_d     = opened_q;
    out_valid_d  = out_valid_q & out_stall_i;
    delta_d      = delta_q;
    sum_d        = sum_q;
    num_d        = num_q;
    den_d        = den_q;
    ln_d         = ln_q;
    ld_d         = ld_q;
    bnum_d       = bnum_q;
    bden_d       = bden_q;
    bf_d         = bf_q;
    prev_cost_d  = prev_cost_q;
    prev_idx_d   = prev_idx_q;
    cand_cost_d  = cand_cost_q;
    cand_idx_d   = cand_idx_q;
    p1_d         = p1_q;
    p2_d         = p2_q;
    p3_d         = p3_q;
    p4_d         = p4_q;
    oc_d         = oc_q;
    of_d         = of_q;
    on_d         = on_q;
    od_d         = od_q;
    osw_d        = osw_q;
    onew_d       = onew_q;
    odone_d      = odone_q;
    olast_d      = olast_q;
    fac_we       = 1'b0;
    fac_waddr    = cand_idx_q;
    cli_ext      = OCW'(cand_idx_q);

    // scan data path: one client per cycle behind the memory read
    if (rdv_q) begin
      if (mode_q == M_SW) begin
        sw_d[jd_q] = served_q[jd_q] && (cur_rdata > conn_rdata);
      end else if (served_q[jd_q]) begin
        if (first_q && mode_q == M_WALK && cur_rdata > conn_rdata) begin
          delta_d = delta_q + SW'(cur_rdata - conn_rdata);
        end
      end else if ((!prev_valid_q || conn_rdata > prev_cost_q
                    || (conn_rdata == prev_cost_q && jd_q > prev_idx_q))
                   && (!cand_valid_q || conn_rdata < cand_cost_q)) begin
        // next client in (cost, index) order after the last one taken
        cand_valid_d = 1'b1;
        cand_cost_d  = conn_rdata;
        cand_idx_d   = jd_q;
      end
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc && req_type_i == gflr_pkg::REQ_ROUND) begin
          if (&served_q) begin
            state_d = S_DONE;
          end else begin
            state_d = S_PRE;
            j_d     = '0;
            ph_d    = 2'd0;
          end
        end
      end
      S_DONE: begin
        if (can_emit) begin
          out_valid_d = 1'b1;
          oc_d    = '0;
          of_d    = '0;
          on_d    = '0;
          od_d    = '0;
          osw_d   = 1'b0;
          onew_d  = 1'b0;
          odone_d = 1'b1;
          olast_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_PRE: begin
        // facility lookup, then cost lookup, then write back
        if (ph_q == 2'd2) begin
          ph_d = 2'd0;
          if (j_q == CJW'(CLIENTS - 1)) begin
            state_d      = S_SCAN;
            mode_d       = M_WALK;
            i_d          = '0;
            j_d          = '0;
            first_d      = 1'b1;
            delta_d      = '0;
            sum_d        = '0;
            k_d          = '0;
            lvalid_d     = 1'b0;
            bvalid_d     = 1'b0;
            prev_valid_d = 1'b0;
            cand_valid_d = 1'b0;
          end else begin
            j_d = j_q + 1'b1;
          end
        end else begin
          ph_d = ph_q + 1'b1;
        end
      end
      S_SCAN: begin
        if (j_q != CJW'(CLIENTS)) begin
          rdv_d = 1'b1;
          j_d   = j_q + 1'b1;
        end else if (!rdv_q) begin
          first_d = 1'b0;
          case (mode_q)
            M_WALK: state_d = S_STEP;
            M_SW: begin
              mode_d       = M_STAR;
              j_d          = '0;
              k_d          = '0;
              prev_valid_d = 1'b0;
              cand_valid_d = 1'b0;
            end
            default: state_d = S_EMS;
          endcase
        end
      end
      S_STEP: begin
        if (!cand_valid_q) begin
          state_d = S_NEXTF;
        end else begin
          sum_d   = sum_q + SW'(cand_cost_q);
          num_d   = $signed(NW'(open_eff)) + $signed(NW'(sum_d)) - $signed(NW'(delta_q));
          den_d   = k_q + 1'b1;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        // cross products for the exact ratio compares
        p1_d    = PW'(num_q) * PW'($signed({1'b0, ld_q}));
        p2_d    = PW'(ln_q) * PW'($signed({1'b0, den_q}));
        p3_d    = PW'(num_q) * PW'($signed({1'b0, bden_q}));
        p4_d    = PW'(bnum_q) * PW'($signed({1'b0, den_q}));
        state_d = S_DEC;
      end
      S_DEC: begin
        if (lvalid_q && !(p1_q < p2_q)) begin
          // ratio stopped falling
          state_d = S_NEXTF;
        end else begin
          ln_d     = num_q;
          ld_d     = den_q;
          lvalid_d = 1'b1;
          if (!bvalid_q || p3_q < p4_q) begin
            bvalid_d = 1'b1;
            bnum_d   = num_q;
            bden_d   = den_q;
            bf_d     = i_q;
          end
          k_d          = den_q;
          prev_valid_d = 1'b1;
          prev_cost_d  = cand_cost_q;
          prev_idx_d   = cand_idx_q;
          cand_valid_d = 1'b0;
          j_d          = '0;
          state_d      = S_SCAN;
        end
      end
      S_NEXTF: begin
        j_d          = '0;
        k_d          = '0;
        prev_valid_d = 1'b0;
        cand_valid_d = 1'b0;
        state_d      = S_SCAN;
        if (i_q == FIW'(FACILITIES - 1)) begin
          // winner known: find the clients it saves on, then redo its walk
          i_d    = bf_q;
          mode_d = M_SW;
        end else begin
          i_d      = i_q + 1'b1;
          first_d  = 1'b1;
          delta_d  = '0;
          sum_d    = '0;
          lvalid_d = 1'b0;
        end
      end
      S_EMS: begin
        if (can_emit) begin
          out_valid_d = 1'b1;
          oc_d    = cli_ext[gflr_pkg::CLI_W-1:0];
          of_d    = fac_ext[gflr_pkg::FAC_W-1:0];
          on_d    = num_ext[gflr_pkg::NUM_W-1:0];
          od_d    = den_ext[gflr_pkg::DEN_W-1:0];
          osw_d   = 1'b0;
          onew_d  = ~opened_q[bf_q];
          odone_d = 1'b0;
          olast_d = (DW'(k_q + 1'b1) == bden_q) && (sw_q == '0);
          fac_we  = 1'b1;
          star_d[cand_idx_q] = 1'b1;
          prev_valid_d = 1'b1;
          prev_cost_d  = cand_cost_q;
          prev_idx_d   = cand_idx_q;
          cand_valid_d = 1'b0;
          k_d          = k_q + 1'b1;
          j_d          = '0;
          state_d      = (DW'(k_q + 1'b1) == bden_q) ? S_SWE : S_SCAN;
        end
      end
      S_SWE: begin
        fac_waddr = jx;
        cli_ext   = OCW'(jx);
        if (j_q == CJW'(CLIENTS)) begin
          state_d = S_FIN;
        end else if (sw_q[jx]) begin
          if (can_emit) begin
            sw_d[jx]    = 1'b0;
            out_valid_d = 1'b1;
            oc_d    = cli_ext[gflr_pkg::CLI_W-1:0];
            of_d    = fac_ext[gflr_pkg::FAC_W-1:0];
            on_d    = num_ext[gflr_pkg::NUM_W-1:0];
            od_d    = den_ext[gflr_pkg::DEN_W-1:0];
            osw_d   = 1'b1;
            onew_d  = ~opened_q[bf_q];
            odone_d = 1'b0;
            olast_d = (sw_d == '0);
            fac_we  = 1'b1;
            j_d     = j_q + 1'b1;
          end
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_FIN: begin
        served_d     = served_q | star_q;
        star_d       = '0;
        opened_d[bf_q] = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      mode_q       <= M_WALK;
      ph_q         <= 2'd0;
      i_q          <= '0;
      j_q          <= '0;
      rdv_q        <= 1'b0;
      first_q      <= 1'b0;
      k_q          <= '0;
      lvalid_q     <= 1'b0;
      bvalid_q     <= 1'b0;
      prev_valid_q <= 1'b0;
      cand_valid_q <= 1'b0;
      served_q     <= '0;
      star_q       <= '0;
      sw_q         <= '0;
      opened_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      mode_q       <= mode_d;
      ph_q         <= ph_d;
      i_q          <= i_d;
      j_q          <= j_d;
      rdv_q        <= rdv_d;
      first_q      <= first_d;
      k_q          <= k_d;
      lvalid_q     <= lvalid_d;
      bvalid_q     <= bvalid_d;
      prev_valid_q <= prev_valid_d;
      cand_valid_q <= cand_valid_d;
      served_q     <= served_d;
      star_q       <= star_d;
      sw_q         <= sw_d;
      opened_q     <= opened_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    jd_q        <= jd_d;
    delta_q     <= delta_d;
    sum_q       <= sum_d;
    num_q       <= num_d;
    den_q       <= den_d;
    ln_q        <= ln_d;
    ld_q        <= ld_d;
    bnum_q      <= bnum_d;
    bden_q      <= bden_d;
    bf_q        <= bf_d;
    prev_cost_q <= prev_cost_d;
    prev_idx_q  <= prev_idx_d;
    cand_cost_q <= cand_cost_d;
    cand_idx_q  <= cand_idx_d;
    p1_q        <= p1_d;
    p2_q        <= p2_d;
    p3_q        <= p3_d;
    p4_q        <= p4_d;
    oc_q        <= oc_d;
    of_q        <= of_d;
    on_q        <= on_d;
    od_q        <= od_d;
    osw_q       <= osw_d;
    onew_q      <= onew_d;
    odone_q     <= odone_d;
    olast_q     <= olast_d;
  end

  assign in_stall_o          = (state_q != S_IDLE);
  assign out_valid_o         = out_valid_q;
  assign client_out_o        = oc_q;
  assign facility_out_o      = of_q;
  assign ratio_numerator_o   = on_q;
  assign ratio_denominator_o = od_q;
  assign switched_o          = osw_q;
  assign newly_opened_o      = onew_q;
  assign all_served_o        = odone_q;
  assign last_o              = olast_q;

  `GFLR_ASSERT_NXT(a_done_item, (state_q == S_DONE) && can_emit, out_valid_o && last_o && all_served_o, "done item not shown")
  `GFLR_ASSERT_IMP(a_den_nonzero, out_valid_o && !all_served_o, ratio_denominator_o != '0, "assigned item with empty star set")
  `GFLR_ASSERT_IMP(a_walk_bound, (state_q == S_EMS) || (state_q == S_SWE), bvalid_q && (bden_q != '0), "emission without a winner")

endmodule

`default_nettype wire
